[rtl/core/csvq_pkg.sv]
// ----------------------------------------------------------------------------
// csvq_pkg
// Shared types and constants for the CSV field quoting encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package csvq_pkg;

	// Field buffer sizing
	localparam int FIELD_MAX = 16;
	localparam int CNT_W     = $clog2(FIELD_MAX + 1);
	localparam int IDX_W     = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;

	// Fixed special bytes
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;

	// Request modes
	typedef enum logic [1:0] {
		MODE_BYTE      = 2'd0,
		MODE_CLOSE_FLD = 2'd1,
		MODE_CLOSE_REC = 2'd2,
		MODE_NONE      = 2'd3
	} mode_t;

	// Quoting styles
	typedef enum logic [1:0] {
		QS_MINIMAL = 2'd0,
		QS_ALL     = 2'd1,
		QS_NONE    = 2'd2,
		QS_NONE_X  = 2'd3
	} quote_style_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_DELIM     = 3'd0,
		REG_QUOTE     = 3'd1,
		REG_ESCAPE    = 3'd2,
		REG_STYLE     = 3'd3,
		REG_DOUBLE_Q  = 3'd4,
		REG_TERM      = 3'd5,
		REG_TERM_LEN  = 3'd6,
		REG_UNUSED    = 3'd7
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELIM,
		ST_OPENQ,
		ST_BYTE,
		ST_CLOSEQ,
		ST_TERM
	} state_t;

endpackage

`default_nettype wire

[rtl/core/csv_field_quote_encoder.sv]
// ----------------------------------------------------------------------------
// csv_field_quote_encoder
// Buffers field bytes and emits encoded CSV text, quoting or escaping each
// field on close and writing the line terminator on record close.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  request   | start / busy         | mode, field_byte
//  result    | strobe (no stall)    | out_byte, last, overflow
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A field byte request is buffered without leaving idle; busy stays low.
//  A field close emits its bytes (delimiter, quotes, escape prefixes, field
//  bytes) from the sequencer, stepping one byte a cycle
//  through the field buffer and the shared special-byte comparator.
//  A record close emits the terminator bytes (none to four).
//  Results are registered and appear in the cycle after they are formed; busy is high meanwhile.
//  Reset clears control state and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_quote_encoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          mode,
	input  wire logic [7:0]          field_byte,
	output logic                     strobe,
	output logic [7:0]               out_byte,
	output logic                     last,
	output logic                     overflow,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import csvq_pkg::*;

	// Configuration registers
	logic [7:0]  delimiter_char_q;
	logic [7:0]  quote_char_q;
	logic [7:0]  escape_char_q;
	logic [1:0]  quote_style_q;
	logic        double_quote_on_q;
	logic [31:0] terminator_bytes_q;
	logic [2:0]  terminator_length_q;

	// Field state
	logic [7:0]       field_store [FIELD_MAX];
	logic [CNT_W-1:0] field_count_q;
	logic             special_seen_q;
	logic             record_started_q;
	logic             dropped_flag_q;

	// Sequencer state
	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             pre_done_q;
	logic             quoted_q;
	logic             ovf_q;
	logic [1:0]       tidx_q;

	// Result registers
	logic       strobe_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       overflow_q;

	// Combinational control
	logic       req_acc;
	logic       cfg_acc;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_last;
	logic       emit_ovf;
	logic       fld_done;
	logic       byte_adv;
	logic       pre_set;
	logic       tidx_adv;
	logic       quoted_new;
	logic       has_bytes;
	logic       idx_is_last;
	logic [2:0] term_len;
	logic       term_last;
	logic [7:0] term_cur;

	// Shared comparator
	logic [7:0] cmp_op;
	logic       cmp_special;
	logic       cmp_quote;
	logic       need_pre;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign req_acc   = start && !busy;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;
	assign overflow = overflow_q;

	// Compare either the incoming byte or the buffered byte under the cursor
	assign cmp_op      = (state_q == ST_IDLE) ? field_byte : field_store[idx_q];
	assign cmp_quote   = (cmp_op == quote_char_q);
	assign cmp_special = (cmp_op == delimiter_char_q) || cmp_quote ||
	                     (cmp_op == escape_char_q) || (cmp_op == CH_LF) ||
	                     (cmp_op == CH_CR);
	assign need_pre    = quoted_q ? cmp_quote : cmp_special;

	// Decide quoting for a field close
	always_comb begin
		case (quote_style_q)
			QS_MINIMAL: quoted_new = special_seen_q;
			QS_ALL:     quoted_new = 1'b1;
			default:    quoted_new = 1'b0;
		endcase
	end

	assign has_bytes   = (field_count_q != '0);
	assign idx_is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == field_count_q);

	// Effective terminator length and last-byte detection
	assign term_len  = ((terminator_length_q == 3'd0) || (terminator_length_q > 3'd4)) ?
	                   3'd4 : terminator_length_q;
	assign term_cur  = terminator_bytes_q[{tidx_q, 3'b000} +: 8];
	always_comb begin
		term_last = ((3'(tidx_q) + 3'd1) == term_len);
		if (tidx_q != 2'd3 &&
		    terminator_bytes_q[{tidx_q + 2'd1, 3'b000} +: 8] == CH_NUL) begin
			term_last = 1'b1;
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and emitted byte
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_byte = cmp_op;
		emit_last = 1'b0;
		emit_ovf  = ovf_q;
		fld_done  = 1'b0;
		byte_adv  = 1'b0;
		pre_set   = 1'b0;
		tidx_adv  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && mode == MODE_CLOSE_FLD) begin
					if (record_started_q) begin
						state_d = ST_DELIM;
					end else if (quoted_new) begin
						state_d = ST_OPENQ;
					end else if (has_bytes) begin
						state_d = ST_BYTE;
					end else begin
						fld_done = 1'b1;
					end
				end else if (req_acc && mode == MODE_CLOSE_REC) begin
					if (terminator_bytes_q[7:0] != CH_NUL) begin
						state_d = ST_TERM;
					end
				end
			end
			ST_DELIM: begin
				emit      = 1'b1;
				emit_byte = delimiter_char_q;
				if (quoted_q) begin
					state_d = ST_OPENQ;
				end else if (has_bytes) begin
					state_d = ST_BYTE;
				end else begin
					emit_last = 1'b1;
					fld_done  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_OPENQ: begin
				emit      = 1'b1;
				emit_byte = quote_char_q;
				state_d   = has_bytes ? ST_BYTE : ST_CLOSEQ;
			end
			ST_BYTE: begin
				emit = 1'b1;
				if (need_pre && !pre_done_q) begin
					emit_byte = (quoted_q && double_quote_on_q) ? quote_char_q : escape_char_q;
					pre_set   = 1'b1;
				end else begin
					emit_byte = cmp_op;
					byte_adv  = 1'b1;
					if (idx_is_last) begin
						if (quoted_q) begin
							state_d = ST_CLOSEQ;
						end else begin
							emit_last = 1'b1;
							fld_done  = 1'b1;
							state_d   = ST_IDLE;
						end
					end
				end
			end
			ST_CLOSEQ: begin
				emit      = 1'b1;
				emit_byte = quote_char_q;
				emit_last = 1'b1;
				fld_done  = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_TERM: begin
				emit      = 1'b1;
				emit_byte = term_cur;
				emit_ovf  = 1'b0;
				tidx_adv  = 1'b1;
				if (term_last) begin
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_char_q    <= 8'd44;
			quote_char_q        <= 8'd34;
			escape_char_q       <= 8'd92;
			quote_style_q       <= QS_MINIMAL;
			double_quote_on_q   <= 1'b1;
			terminator_bytes_q  <= 32'd2573;
			terminator_length_q <= 3'd2;
		end else if (cfg_acc) begin
			case (reg_idx_t'(cfg_index))
				REG_DELIM:    delimiter_char_q    <= cfg_data[7:0];
				REG_QUOTE:    quote_char_q        <= cfg_data[7:0];
				REG_ESCAPE:   escape_char_q       <= cfg_data[7:0];
				REG_STYLE:    quote_style_q       <= cfg_data[1:0];
				REG_DOUBLE_Q: double_quote_on_q   <= cfg_data[0];
				REG_TERM:     terminator_bytes_q  <= cfg_data;
				REG_TERM_LEN: terminator_length_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Buffer incoming field bytes
	always_ff @(posedge clk) begin
		if (req_acc && mode == MODE_BYTE && field_count_q < CNT_W'(FIELD_MAX)) begin
			field_store[field_count_q[IDX_W-1:0]] <= field_byte;
		end
	end

	// Track field and record marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q    <= '0;
			special_seen_q   <= 1'b0;
			record_started_q <= 1'b0;
			dropped_flag_q   <= 1'b0;
		end else if (req_acc && mode == MODE_BYTE) begin
			if (field_count_q < CNT_W'(FIELD_MAX)) begin
				field_count_q <= field_count_q + CNT_W'(1);
				if (cmp_special) begin
					special_seen_q <= 1'b1;
				end
			end else begin
				dropped_flag_q <= 1'b1;
			end
		end else if (req_acc && mode == MODE_CLOSE_REC) begin
			field_count_q    <= '0;
			special_seen_q   <= 1'b0;
			dropped_flag_q   <= 1'b0;
			record_started_q <= 1'b0;
		end else if (fld_done) begin
			field_count_q    <= '0;
			special_seen_q   <= 1'b0;
			dropped_flag_q   <= 1'b0;
			record_started_q <= 1'b1;
		end
	end

	// Advance the field and terminator cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			pre_done_q <= 1'b0;
			quoted_q   <= 1'b0;
			ovf_q      <= 1'b0;
			tidx_q     <= 2'd0;
		end else begin
			if (req_acc) begin
				idx_q      <= '0;
				pre_done_q <= 1'b0;
				quoted_q   <= quoted_new;
				ovf_q      <= dropped_flag_q;
				tidx_q     <= 2'd0;
			end else begin
				if (pre_set) begin
					pre_done_q <= 1'b1;
				end
				if (byte_adv) begin
					pre_done_q <= 1'b0;
					idx_q      <= idx_q + IDX_W'(1);
				end
				if (tidx_adv) begin
					tidx_q <= tidx_q + 2'd1;
				end
			end
		end
	end

	// Register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
			overflow_q <= emit_ovf;
		end
	end

	// Results only follow a busy cycle
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q != ST_IDLE))
		else $error("result without an active sequence");

	// A result that is not last leaves the sequencer running
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("sequence ended without a last result");

	// Field count stays within the buffer
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		field_count_q <= CNT_W'(FIELD_MAX))
		else $error("field count beyond buffer size");

	// Terminator results never carry overflow
	a_term_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(state_q == ST_TERM)) |-> !overflow)
		else $error("overflow on terminator byte");

	// A new request is never taken while busy
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_acc)
		else $error("request accepted while busy");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSV field quoting encoder. A queue of requests
// and register writes, filled up front, feeds a falling-edge driver that sends
// in random bursts. A rising-edge monitor keeps a shadow encoder, predicts the
// encoded text for every accepted request and checks each strobed byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import csvq_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 24;
	localparam int NUM_PHASES     = 10;

	typedef enum logic {OP_REQ, OP_REG} op_kind_t;

	typedef struct {
		op_kind_t    kind;
		mode_t       md;
		logic [7:0]  fb;
		reg_idx_t    idx;
		logic [31:0] data;
	} bus_op_t;

	typedef struct {
		logic [7:0]   delim;
		logic [7:0]   quote;
		logic [7:0]   esc;
		quote_style_t style;
		logic         dbl;
		logic [31:0]  term;
		logic [2:0]   tlen;
	} csv_regs_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       ovf;
	} csv_out_t;

	// DUT inputs, all known from time zero
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  mode       = '0;
	logic [7:0]  field_byte = '0;
	logic        cfg_valid  = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [31:0] cfg_data   = '0;
	logic        busy;
	logic        cfg_ready;
	logic        strobe;
	logic [7:0]  out_byte;
	logic        last;
	logic        overflow;

	// Request plan and driver bookkeeping
	bus_op_t   pending_ops[$];
	csv_regs_t plan_regs;
	int        plan_items  = 0;
	int        reqs_sent   = 0;
	int        reqs_taken  = 0;
	int        regs_sent   = 0;
	int        regs_taken  = 0;
	int        burst_left  = 0;
	int        gap_left    = 0;

	// Shadow encoder state
	csv_regs_t  live_regs;
	logic [7:0] fld_buf [FIELD_MAX];
	int         fld_cnt     = 0;
	logic       fld_special = 1'b0;
	logic       fld_dropped = 1'b0;
	logic       rec_open    = 1'b0;
	csv_out_t   csv_text_q[$];

	// Run statistics
	int quiet_cycles = 0;
	int stall_cycles = 0;
	int err_count    = 0;
	int byte_count   = 0;
	int ovf_count    = 0;
	int item_count   = 0;
	int reg_count    = 0;

	csv_field_quote_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.field_byte (field_byte),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.last       (last),
		.overflow   (overflow),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// Register file helpers
	// ------------------------------------------------------------------------
	function automatic csv_regs_t default_regs();
		csv_regs_t r;
		r.delim = 8'd44;
		r.quote = 8'd34;
		r.esc   = 8'd92;
		r.style = QS_MINIMAL;
		r.dbl   = 1'b1;
		r.term  = 32'h0000_0A0D;
		r.tlen  = 3'd2;
		return r;
	endfunction

	function automatic csv_regs_t with_reg(csv_regs_t r, reg_idx_t i, logic [31:0] d);
		case (i)
			REG_DELIM:    r.delim = d[7:0];
			REG_QUOTE:    r.quote = d[7:0];
			REG_ESCAPE:   r.esc   = d[7:0];
			REG_STYLE:    r.style = quote_style_t'(d[1:0]);
			REG_DOUBLE_Q: r.dbl   = d[0];
			REG_TERM:     r.term  = d;
			REG_TERM_LEN: r.tlen  = d[2:0];
			default: ;
		endcase
		return r;
	endfunction

	// Fill the bits above the register width with noise
	function automatic logic [31:0] pad_hi(logic [31:0] v, int unsigned w);
		logic [31:0] m;
		m = (32'd1 << w) - 32'd1;
		return ({$urandom} & ~m) | (v & m);
	endfunction

	// ------------------------------------------------------------------------
	// Shadow encoder
	// ------------------------------------------------------------------------
	function automatic logic is_special_byte(logic [7:0] b);
		return b == live_regs.delim || b == live_regs.quote || b == live_regs.esc ||
			b == CH_LF || b == CH_CR;
	endfunction

	function automatic void emit_byte(logic [7:0] ch, logic ovf);
		csv_out_t o;
		o.ch   = ch;
		o.last = 1'b0;
		o.ovf  = ovf;
		csv_text_q.push_back(o);
	endfunction

	task automatic encode_request(input mode_t m, input logic [7:0] b);
		int         n0;
		int         tl;
		logic       quoted;
		logic       ovf;
		logic [7:0] c;
		csv_out_t   tail;
		n0 = csv_text_q.size();
		case (m)
			MODE_BYTE: begin
				// buffer the byte, or drop it once the field is full
				if (fld_cnt < FIELD_MAX) begin
					fld_buf[IDX_W'(fld_cnt)] = b;
					fld_cnt++;
					if (is_special_byte(b))
						fld_special = 1'b1;
				end else begin
					fld_dropped = 1'b1;
				end
			end
			MODE_CLOSE_FLD: begin
				ovf = fld_dropped;
				case (live_regs.style)
					QS_ALL:     quoted = 1'b1;
					QS_MINIMAL: quoted = fld_special;
					default:    quoted = 1'b0;
				endcase
				if (rec_open)
					emit_byte(live_regs.delim, ovf);
				if (quoted)
					emit_byte(live_regs.quote, ovf);
				for (int i = 0; i < fld_cnt; i++) begin
					c = fld_buf[IDX_W'(i)];
					if (quoted) begin
						if (c == live_regs.quote)
							emit_byte(live_regs.dbl ? live_regs.quote : live_regs.esc, ovf);
					end else if (is_special_byte(c)) begin
						emit_byte(live_regs.esc, ovf);
					end
					emit_byte(c, ovf);
				end
				if (quoted)
					emit_byte(live_regs.quote, ovf);
				fld_cnt     = 0;
				fld_special = 1'b0;
				fld_dropped = 1'b0;
				rec_open    = 1'b1;
			end
			MODE_CLOSE_REC: begin
				// terminator stops early at a zero byte
				tl = int'(live_regs.tlen);
				if (tl == 0 || tl > 4)
					tl = 4;
				for (int i = 0; i < tl; i++) begin
					c = live_regs.term[8*i +: 8];
					if (c == CH_NUL)
						break;
					emit_byte(c, 1'b0);
				end
				fld_cnt     = 0;
				fld_special = 1'b0;
				fld_dropped = 1'b0;
				rec_open    = 1'b0;
			end
			default: ;
		endcase
		if (csv_text_q.size() > n0) begin
			tail = csv_text_q.pop_back();
			tail.last = 1'b1;
			csv_text_q.push_back(tail);
		end
	endtask

	// ------------------------------------------------------------------------
	// Request planning
	// ------------------------------------------------------------------------
	task automatic queue_request(input mode_t m, input logic [7:0] b);
		bus_op_t op;
		op.kind = OP_REQ;
		op.md   = m;
		op.fb   = b;
		op.idx  = REG_UNUSED;
		op.data = '0;
		pending_ops.push_back(op);
		if (m != MODE_NONE)
			plan_items++;
	endtask

	task automatic queue_reg_write(input reg_idx_t i, input logic [31:0] v);
		bus_op_t op;
		op.kind = OP_REG;
		op.md   = MODE_NONE;
		op.fb   = '0;
		op.idx  = i;
		op.data = v;
		pending_ops.push_back(op);
		plan_regs = with_reg(plan_regs, i, v);
	endtask

	task automatic queue_all_regs(input logic [7:0] d, input logic [7:0] q, input logic [7:0] e,
			input quote_style_t s, input logic dq, input logic [31:0] t, input logic [2:0] tl);
		queue_reg_write(REG_DELIM, pad_hi(32'(d), 8));
		queue_reg_write(REG_QUOTE, pad_hi(32'(q), 8));
		queue_reg_write(REG_ESCAPE, pad_hi(32'(e), 8));
		queue_reg_write(REG_STYLE, pad_hi(32'(s), 2));
		queue_reg_write(REG_DOUBLE_Q, pad_hi(32'(dq), 1));
		queue_reg_write(REG_TERM, t);
		queue_reg_write(REG_TERM_LEN, pad_hi(32'(tl), 3));
	endtask

	// Lean toward the bytes that force quoting or escaping
	function automatic logic [7:0] pick_field_byte();
		case ($urandom_range(0, 9))
			0:       return plan_regs.delim;
			1:       return plan_regs.quote;
			2:       return plan_regs.esc;
			3:       return $urandom_range(0, 1) ? CH_LF : CH_CR;
			default: return 8'($urandom);
		endcase
	endfunction

	// One record of random fields, now and then left broken
	task automatic queue_record();
		int nfld;
		int len;
		nfld = $urandom_range(1, 4);
		for (int f = 0; f < nfld; f++) begin
			case ($urandom_range(0, 19)) inside
				[0:11]:  len = $urandom_range(0, 5);
				[12:16]: len = $urandom_range(6, FIELD_MAX);
				default: len = $urandom_range(FIELD_MAX + 1, FIELD_MAX + 5);
			endcase
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 39) == 0)
					queue_request(MODE_NONE, 8'($urandom));
				queue_request(MODE_BYTE, pick_field_byte());
			end
			if ($urandom_range(0, 11) != 0)
				queue_request(MODE_CLOSE_FLD, 8'($urandom));
		end
		if ($urandom_range(0, 5) != 0)
			queue_request(MODE_CLOSE_REC, 8'($urandom));
	endtask

	task automatic queue_phase(input int ph);
		int target;
		case (ph)
			1: begin
				queue_all_regs(8'hFF, 8'h00, 8'h7F, QS_ALL, 1'b0, 32'hFFFF_FFFF, 3'd4);
				queue_reg_write(REG_UNUSED, $urandom);
			end
			2: queue_all_regs(8'h00, 8'hFF, 8'h80, QS_NONE, 1'b1, 32'h1234_5600, 3'd0);
			3: queue_all_regs(8'h09, 8'h27, 8'h5C, QS_NONE_X, 1'b0, 32'h000A_0D41, 3'd7);
			4: queue_all_regs(8'h2C, 8'h22, 8'h22, QS_MINIMAL, 1'b0, 32'h0000_000A, 3'd1);
			5: queue_all_regs(8'h3B, 8'h22, 8'h5C, QS_MINIMAL, 1'b1, 32'h0D0A_0D0A, 3'd5);
			6: queue_all_regs(8'hFF, 8'hFF, 8'hFF, QS_ALL, 1'b1, 32'h0000_0000, 3'd1);
			default: queue_all_regs(8'($urandom), 8'($urandom), 8'($urandom),
				quote_style_t'($urandom_range(0, 3)), 1'($urandom), $urandom,
				3'($urandom_range(0, 7)));
		endcase
		target = plan_items + PHASE_ITEMS;
		while (plan_items < target)
			queue_record();
	endtask

	// ------------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("ERROR @%0t byte %0d: %s expected %0h got %0h", $time, byte_count, what,
			want, got);
		err_count++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: present requests and register writes on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive_proc
		logic        n_start;
		logic [1:0]  n_mode;
		logic [7:0]  n_byte;
		logic        n_valid;
		logic [2:0]  n_index;
		logic [31:0] n_data;
		logic        req_out;
		logic        reg_out;
		bus_op_t     op;
		n_start = start;
		n_mode  = mode;
		n_byte  = field_byte;
		n_valid = cfg_valid;
		n_index = cfg_index;
		n_data  = cfg_data;
		req_out = (reqs_taken != reqs_sent);
		reg_out = (regs_taken != regs_sent);
		if (arst_n) begin
			if (!req_out)
				n_start = 1'b0;
			if (!reg_out)
				n_valid = 1'b0;
			if (!req_out && !reg_out && pending_ops.size() != 0) begin
				if (pending_ops[0].kind == OP_REG) begin
					// write registers only once the encoder has gone quiet
					if (csv_text_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
						op = pending_ops.pop_front();
						n_valid = 1'b1;
						n_index = op.idx;
						n_data  = op.data;
						regs_sent++;
					end
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					op = pending_ops.pop_front();
					n_start = 1'b1;
					n_mode  = op.md;
					n_byte  = op.fb;
					reqs_sent++;
					// pick the next burst and the gap that follows it
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 20);
						case ($urandom_range(0, 7))
							0, 1, 2: gap_left = 0;
							3:       gap_left = $urandom_range(10, 30);
							default: gap_left = $urandom_range(1, 4);
						endcase
					end
				end
			end
		end
		start      <= n_start;
		mode       <= n_mode;
		field_byte <= n_byte;
		cfg_valid  <= n_valid;
		cfg_index  <= n_index;
		cfg_data   <= n_data;
	end

	// ------------------------------------------------------------------------
	// Monitor: check results, track accepted requests, watch for hangs
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_proc
		csv_out_t want;
		logic     moved;
		if (arst_n) begin
			moved = 1'b0;
			// check the strobed byte against the oldest prediction
			if (strobe) begin
				moved = 1'b1;
				if (csv_text_q.size() == 0) begin
					flag_mismatch("unexpected out_byte", '0, 32'(out_byte));
				end else begin
					want = csv_text_q.pop_front();
					if (out_byte !== want.ch)
						flag_mismatch("out_byte", 32'(want.ch), 32'(out_byte));
					if (last !== want.last)
						flag_mismatch("last", 32'(want.last), 32'(last));
					if (overflow !== want.ovf)
						flag_mismatch("overflow", 32'(want.ovf), 32'(overflow));
					if (want.ovf)
						ovf_count++;
				end
				byte_count++;
			end
			// advance the shadow registers
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				live_regs = with_reg(live_regs, reg_idx_t'(cfg_index), cfg_data);
				regs_taken++;
				reg_count++;
			end
			// predict the text for each accepted request
			if (start && !busy) begin
				moved = 1'b1;
				encode_request(mode_t'(mode), field_byte);
				reqs_taken++;
				item_count++;
			end
			if (!busy && !strobe && !start && csv_text_q.size() == 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d bytes still due",
					stall_cycles, csv_text_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Plan the run, release reset, wait for the encoder to drain
	// ------------------------------------------------------------------------
	initial begin
		live_regs = default_regs();
		plan_regs = default_regs();

		// Directed: reset settings, empty fields, quoting, escaping, ignored mode
		queue_request(MODE_CLOSE_FLD, 8'hA5);
		queue_request(MODE_BYTE, 8'h61);
		queue_request(MODE_BYTE, 8'h2C);
		queue_request(MODE_CLOSE_FLD, 8'h5A);
		queue_request(MODE_BYTE, 8'h22);
		queue_request(MODE_CLOSE_FLD, 8'hFF);
		queue_request(MODE_NONE, 8'h00);
		queue_request(MODE_BYTE, 8'h00);
		queue_request(MODE_BYTE, 8'hFF);
		queue_request(MODE_BYTE, CH_LF);
		queue_request(MODE_BYTE, CH_CR);
		queue_request(MODE_BYTE, 8'h5C);
		queue_request(MODE_CLOSE_FLD, 8'h00);
		queue_request(MODE_BYTE, 8'h55);
		queue_request(MODE_BYTE, 8'hAA);
		queue_request(MODE_CLOSE_FLD, 8'h81);
		queue_request(MODE_CLOSE_REC, 8'h7E);
		queue_request(MODE_BYTE, 8'h78);
		queue_request(MODE_CLOSE_REC, 8'h01);
		queue_request(MODE_CLOSE_FLD, 8'h80);
		queue_request(MODE_CLOSE_FLD, 8'h7F);
		queue_request(MODE_CLOSE_REC, 8'hFE);

		for (int ph = 1; ph < NUM_PHASES; ph++)
			queue_phase(ph);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || reqs_taken != reqs_sent ||
				regs_taken != regs_sent || csv_text_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d requests and %0d register writes over %0d settings",
			item_count, reg_count, NUM_PHASES);
		$display("checked %0d output bytes, %0d of them flagged for buffer overflow",
			byte_count, ovf_count);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
